@@ rtl/udrg_pkg.sv @@
`timescale 1ns / 1ps

package udrg_pkg;

  // payload widths
  localparam int ID_W    = 12;
  localparam int KEY_W   = 32;
  localparam int PORT_W  = 9;
  localparam int HOP_W   = 4;
  localparam int RADIX_W = 8;
  localparam int STG_W   = 4;

  // configuration port
  localparam int DATA_W    = 64;
  localparam int ADDR_W    = 5;
  localparam int REG_SHIFT = 3;
  localparam int PACK_W    = 40;

  // shared divider: 32-bit dividend, eight quotient bits per cycle
  localparam int DIV_W     = 32;
  localparam int SHORT_W   = 16;
  localparam int DIV_STEP  = 8;
  localparam int LONG_CYC  = DIV_W / DIV_STEP;
  localparam int SHORT_CYC = SHORT_W / DIV_STEP;
  localparam int CNT_W     = 3;

  // routing modes
  localparam logic [1:0] MODE_STATIC = 2'd0;
  localparam logic [1:0] MODE_RANDOM = 2'd1;
  localparam logic [1:0] MODE_RR     = 2'd2;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_STAGES = 2'd1,
    REG_DOWN   = 2'd2,
    REG_UP     = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        mode;
    logic [2:0]        stages;
    logic [PACK_W-1:0] down_radices;
    logic [PACK_W-1:0] up_radices;
  } cfg_t;

  typedef struct packed {
    logic start;
    logic long_op;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // byte s of a packed radix word, zero beyond the fifth byte
  function automatic logic [RADIX_W-1:0] radix_at(input logic [PACK_W-1:0] radices,
                                                  input logic [STG_W-1:0] s);
    logic [RADIX_W-1:0] r;
    begin
      case (s)
        4'd0:    r = radices[7:0];
        4'd1:    r = radices[15:8];
        4'd2:    r = radices[23:16];
        4'd3:    r = radices[31:24];
        4'd4:    r = radices[39:32];
        default: r = '0;
      endcase
      return r;
    end
  endfunction

endpackage

@@ rtl/udrg_ifs.sv @@
`timescale 1ns / 1ps

// route request channel
interface udrg_req_if;
  import udrg_pkg::*;
  logic             valid;
  logic             ready;
  logic [ID_W-1:0]  src_server;
  logic [ID_W-1:0]  dst_server;
  logic [KEY_W-1:0] random_value;

  modport source (output valid, src_server, dst_server, random_value, input ready);
  modport sink   (input valid, src_server, dst_server, random_value, output ready);
endinterface

// hop result channel
interface udrg_hop_if;
  import udrg_pkg::*;
  logic              valid;
  logic              ready;
  logic [PORT_W-1:0] out_port;
  logic [HOP_W-1:0]  hop_number;
  logic              last_hop;
  logic              error;

  modport source (output valid, out_port, hop_number, last_hop, error, input ready);
  modport sink   (input valid, out_port, hop_number, last_hop, error, output ready);
endinterface

@@ rtl/udrg_regs.sv @@
`timescale 1ns / 1ps

module udrg_regs (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [udrg_pkg::ADDR_W-1:0]  paddr,
  input  logic [udrg_pkg::DATA_W-1:0]  pwdata,
  output logic [udrg_pkg::DATA_W-1:0]  prdata,
  output logic                         pready,
  output udrg_pkg::cfg_t               cfg
);
  import udrg_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[ADDR_W-1:REG_SHIFT]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.mode         <= MODE_STATIC;
      cfg.stages       <= 3'd1;
      cfg.down_radices <= PACK_W'(2);
      cfg.up_radices   <= PACK_W'(1);
    end else if (wr_en) begin
      case (idx)
        REG_MODE:   cfg.mode         <= pwdata[1:0];
        REG_STAGES: cfg.stages       <= pwdata[2:0];
        REG_DOWN:   cfg.down_radices <= pwdata[PACK_W-1:0];
        REG_UP:     cfg.up_radices   <= pwdata[PACK_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_MODE:   prdata = DATA_W'(cfg.mode);
      REG_STAGES: prdata = DATA_W'(cfg.stages);
      REG_DOWN:   prdata = DATA_W'(cfg.down_radices);
      REG_UP:     prdata = DATA_W'(cfg.up_radices);
      default:    prdata = '0;
    endcase
  end

endmodule

@@ rtl/udrg_div.sv @@
`timescale 1ns / 1ps

module udrg_div #(
  parameter int DVW = 13
) (
  input  logic                        clk,
  input  logic                        rst,
  input  udrg_pkg::div_ctl_t          ctl,
  input  logic [udrg_pkg::DIV_W-1:0]  dividend,
  input  logic [DVW-1:0]              divisor,
  output udrg_pkg::div_sts_t          sts,
  output logic [udrg_pkg::DIV_W-1:0]  quot,
  output logic [DVW-1:0]              rem
);
  import udrg_pkg::*;

  logic [DIV_W-1:0] dq;
  logic [DIV_W-1:0] dq_next;
  logic [DVW-1:0]   r;
  logic [DVW-1:0]   r_next;
  logic [DVW-1:0]   dvs;
  logic [CNT_W-1:0] cnt;
  logic             long_q;
  logic             busy;
  logic             done;

  // eight restoring steps per cycle
  always_comb begin
    logic [DVW:0] t;
    dq_next = dq;
    r_next  = r;
    for (int k = 0; k < DIV_STEP; k++) begin
      t       = {r_next, dq_next[DIV_W-1]};
      dq_next = {dq_next[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, dvs}) begin
        r_next     = DVW'(t - {1'b0, dvs});
        dq_next[0] = 1'b1;
      end else begin
        r_next = t[DVW-1:0];
      end
    end
  end

  // step count and completion pulse
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= ctl.long_op ? CNT_W'(LONG_CYC) : CNT_W'(SHORT_CYC);
      end else if (busy) begin
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt - 1'b1;
      end
    end
  end

  // short operands are left aligned so only their sixteen bits are stepped
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      dq     <= ctl.long_op ? dividend
                            : {dividend[SHORT_W-1:0], {(DIV_W-SHORT_W){1'b0}}};
      r      <= '0;
      dvs    <= divisor;
      long_q <= ctl.long_op;
    end else if (busy) begin
      dq <= dq_next;
      r  <= r_next;
    end
  end

  assign quot     = long_q ? dq : DIV_W'(dq[SHORT_W-1:0]);
  assign rem      = r;
  assign sts.busy = busy;
  assign sts.done = done;

endmodule

@@ rtl/updown_tree_route_generator_core.sv @@
`timescale 1ns / 1ps

// Up/down route generator for a generalised multi-stage tree. A request item carries a source
// and destination server; the block answers with 2*mca hop items (port, hop number, last flag),
// or a single error item when either id is not below the server count, or nothing when source
// equals destination. One request is handled at a time and all division goes through one
// shared divider (eight quotient bits per cycle, on a 16-bit or a 32-bit dividend). A route
// first forms the product of the down radices, checks both ids and searches for the common
// stage with two divisions per stage, then emits its hops. Each up hop sets up its modulo and
// waits on the divider (a 32-bit operand with the random key, no division for a zero up
// radix), and a key quotient is taken between up hops. A closing state follows, in round-robin
// mode with a division for the offset update, before the block goes back to idle to take the
// next request; a stalled hop channel holds the route at each hop. After reset the round-robin
// offset memory is initialised one entry per cycle, during which no request is taken; the
// configuration port is writable throughout.
module updown_tree_route_generator_core #(
  parameter int MAX_SERVERS = 4096,
  parameter int MAX_STAGES  = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  udrg_req_if.sink                     req,
  udrg_hop_if.source                   route,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [udrg_pkg::ADDR_W-1:0]  paddr,
  input  logic [udrg_pkg::DATA_W-1:0]  pwdata,
  output logic [udrg_pkg::DATA_W-1:0]  prdata,
  output logic                         pready
);
  import udrg_pkg::*;

  localparam int AW  = $clog2(MAX_SERVERS);
  localparam int CW  = $clog2(MAX_SERVERS + 1);
  localparam int DVW = (CW > RADIX_W) ? CW : RADIX_W;
  localparam int SIW = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;

  typedef enum logic [15:0] {
    S_CLEAR    = 16'h0001,
    S_IDLE     = 16'h0002,
    S_PROD     = 16'h0004,
    S_CHECK    = 16'h0008,
    S_MCA      = 16'h0010,
    S_WAIT_S   = 16'h0020,
    S_WAIT_D   = 16'h0040,
    S_HOP0     = 16'h0080,
    S_UP_MOD   = 16'h0100,
    S_WAIT_MOD = 16'h0200,
    S_UP_EMIT  = 16'h0400,
    S_WAIT_QUO = 16'h0800,
    S_DOWN     = 16'h1000,
    S_RR       = 16'h2000,
    S_WAIT_RR  = 16'h4000,
    S_ERR      = 16'h8000
  } state_t;

  state_t state;
  state_t state_next;
  cfg_t   cfg;

  // request and working registers
  logic [ID_W-1:0]    src_reg;
  logic [ID_W-1:0]    dst_reg;
  logic [KEY_W-1:0]   rnd_reg;
  logic [ID_W-1:0]    qs;
  logic [ID_W-1:0]    qd;
  logic [KEY_W-1:0]   kq;
  logic               key_long;
  logic [STG_W-1:0]   s_idx;
  logic [STG_W-1:0]   m;
  logic [STG_W-1:0]   j;
  logic [STG_W-1:0]   lv;
  logic [RADIX_W-1:0] up_rem;
  logic [RADIX_W-1:0] dig [MAX_STAGES];
  logic [CW-1:0]      prod;
  logic               sat;

  // derived values
  logic [STG_W-1:0]   ns;
  logic [CW-1:0]      count;
  logic [CW+7:0]      prod_full;
  logic [RADIX_W-1:0] d_s;
  logic [RADIX_W-1:0] d_j;
  logic [RADIX_W-1:0] u_j;
  logic               id_bad;
  logic               out_free;

  // offset memory
  logic [AW-1:0] rr_mem [MAX_SERVERS];
  logic [AW-1:0] rr_q;
  logic [AW-1:0] rd_addr;
  logic [AW-1:0] clr_idx;
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [AW-1:0] mem_wd;

  // shared divider
  div_ctl_t         div_ctl;
  div_sts_t         div_sts;
  logic [DIV_W-1:0] div_dividend;
  logic [DVW-1:0]   div_divisor;
  logic [DIV_W-1:0] div_quot;
  logic [DVW-1:0]   div_rem;

  // hop output register
  logic              hop_valid;
  logic [PORT_W-1:0] port_q;
  logic [HOP_W-1:0]  hop_q;
  logic              last_q;
  logic              err_q;
  logic              emit_en;
  logic [PORT_W-1:0] emit_port;
  logic [HOP_W-1:0]  emit_hop;
  logic              emit_last;
  logic              emit_err;

  udrg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  udrg_div #(
    .DVW (DVW)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .sts      (div_sts),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  // stage count capped at the build limit
  assign ns = (STG_W'(cfg.stages) > STG_W'(MAX_STAGES)) ? STG_W'(MAX_STAGES)
                                                         : STG_W'(cfg.stages);

  assign d_s       = radix_at(cfg.down_radices, s_idx);
  assign d_j       = radix_at(cfg.down_radices, j);
  assign u_j       = radix_at(cfg.up_radices, j);
  assign prod_full = (CW+8)'(prod) * (CW+8)'(d_s);
  assign count     = sat ? CW'(MAX_SERVERS) : prod;
  assign id_bad    = (32'(src_reg) >= 32'(count)) || (32'(dst_reg) >= 32'(count));
  assign out_free  = !hop_valid || route.ready;
  assign rd_addr   = (state == S_IDLE) ? AW'(req.src_server) : AW'(src_reg);

  assign req.ready        = (state == S_IDLE);
  assign route.valid      = hop_valid;
  assign route.out_port   = port_q;
  assign route.hop_number = hop_q;
  assign route.last_hop   = last_q;
  assign route.error      = err_q;

  // sequencer control
  always_comb begin
    state_next   = state;
    div_ctl      = '{start: 1'b0, long_op: 1'b0};
    div_dividend = '0;
    div_divisor  = '0;
    emit_en      = 1'b0;
    emit_port    = '0;
    emit_hop     = '0;
    emit_last    = 1'b0;
    emit_err     = 1'b0;
    mem_we       = 1'b0;
    mem_wa       = AW'(src_reg);
    mem_wd       = AW'(div_rem);
    case (state)
      S_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_idx;
        mem_wd = clr_idx;
        if (clr_idx == AW'(MAX_SERVERS - 1)) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (req.valid) state_next = S_PROD;
      end
      S_PROD: begin
        if (s_idx >= ns) state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = id_bad ? S_ERR : S_MCA;
      end
      S_MCA: begin
        if (qs == qd || s_idx == ns) begin
          state_next = (s_idx == '0) ? S_RR : S_HOP0;
        end else begin
          div_ctl      = '{start: 1'b1, long_op: 1'b0};
          div_dividend = DIV_W'(qs);
          div_divisor  = DVW'(d_s);
          state_next   = S_WAIT_S;
        end
      end
      S_WAIT_S: begin
        if (div_sts.done) begin
          div_ctl      = '{start: 1'b1, long_op: 1'b0};
          div_dividend = DIV_W'(qd);
          div_divisor  = DVW'(d_s);
          state_next   = S_WAIT_D;
        end
      end
      S_WAIT_D: begin
        if (div_sts.done) state_next = S_MCA;
      end
      S_HOP0: begin
        if (out_free) begin
          emit_en    = 1'b1;
          state_next = (m > STG_W'(1)) ? S_UP_MOD : S_DOWN;
        end
      end
      S_UP_MOD: begin
        if (u_j == '0) begin
          state_next = S_UP_EMIT;
        end else begin
          div_ctl      = '{start: 1'b1, long_op: key_long};
          div_dividend = kq;
          div_divisor  = DVW'(u_j);
          state_next   = S_WAIT_MOD;
        end
      end
      S_WAIT_MOD: begin
        if (div_sts.done) state_next = S_UP_EMIT;
      end
      S_UP_EMIT: begin
        if (out_free) begin
          emit_en   = 1'b1;
          emit_port = PORT_W'(d_j) + PORT_W'(up_rem);
          emit_hop  = HOP_W'(j + STG_W'(1));
          if (j + STG_W'(2) < m) begin
            div_ctl      = '{start: 1'b1, long_op: key_long};
            div_dividend = kq;
            div_divisor  = DVW'(d_j);
            state_next   = S_WAIT_QUO;
          end else begin
            state_next = S_DOWN;
          end
        end
      end
      S_WAIT_QUO: begin
        if (div_sts.done) state_next = S_UP_MOD;
      end
      S_DOWN: begin
        if (out_free) begin
          emit_en   = 1'b1;
          emit_port = PORT_W'(dig[SIW'(lv)]);
          emit_hop  = HOP_W'((m << 1) - STG_W'(1) - lv);
          emit_last = (lv == '0);
          if (lv == '0) state_next = S_RR;
        end
      end
      S_RR: begin
        if (cfg.mode == MODE_RR) begin
          div_ctl      = '{start: 1'b1, long_op: 1'b1};
          div_dividend = DIV_W'(rr_q) + DIV_W'(1);
          div_divisor  = DVW'(count);
          state_next   = S_WAIT_RR;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_WAIT_RR: begin
        if (div_sts.done) begin
          mem_we     = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_ERR: begin
        if (out_free) begin
          emit_en    = 1'b1;
          emit_last  = 1'b1;
          emit_err   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      clr_idx   <= '0;
      hop_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + 1'b1;
      if (emit_en) begin
        hop_valid <= 1'b1;
      end else if (route.ready) begin
        hop_valid <= 1'b0;
      end
    end
  end

  // hop payload
  always_ff @(posedge clk) begin
    if (emit_en) begin
      port_q <= emit_port;
      hop_q  <= emit_hop;
      last_q <= emit_last;
      err_q  <= emit_err;
    end
  end

  // working registers per step
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (req.valid) begin
          src_reg <= req.src_server;
          dst_reg <= req.dst_server;
          rnd_reg <= req.random_value;
          s_idx   <= '0;
          prod    <= CW'(1);
          sat     <= 1'b0;
        end
      end
      S_PROD: begin
        // running product of down radices, saturated above the server limit; a zero radix forces it to zero
        if (s_idx < ns) begin
          if (d_s == '0) begin
            prod <= '0;
            sat  <= 1'b0;
          end else if (!sat) begin
            if (prod_full > (CW+8)'(MAX_SERVERS)) begin
              sat <= 1'b1;
            end else begin
              prod <= CW'(prod_full);
            end
          end
          s_idx <= s_idx + STG_W'(1);
        end
      end
      S_CHECK: begin
        qs       <= src_reg;
        qd       <= dst_reg;
        s_idx    <= '0;
        key_long <= (cfg.mode == MODE_RANDOM);
        case (cfg.mode)
          MODE_RANDOM: kq <= rnd_reg;
          MODE_RR:     kq <= KEY_W'(rr_q);
          default:     kq <= KEY_W'(src_reg);
        endcase
      end
      S_MCA: begin
        if (qs == qd || s_idx == ns) begin
          m  <= s_idx;
          lv <= s_idx - STG_W'(1);
          j  <= '0;
        end
      end
      S_WAIT_S: begin
        if (div_sts.done) qs <= ID_W'(div_quot);
      end
      S_WAIT_D: begin
        if (div_sts.done) begin
          qd                <= ID_W'(div_quot);
          dig[SIW'(s_idx)]  <= div_rem[RADIX_W-1:0];
          s_idx             <= s_idx + STG_W'(1);
        end
      end
      S_UP_MOD: begin
        if (u_j == '0) up_rem <= '0;
      end
      S_WAIT_MOD: begin
        if (div_sts.done) up_rem <= div_rem[RADIX_W-1:0];
      end
      S_WAIT_QUO: begin
        if (div_sts.done) begin
          kq <= div_quot;
          j  <= j + STG_W'(1);
        end
      end
      S_DOWN: begin
        if (out_free && lv != '0) lv <= lv - STG_W'(1);
      end
      default: ;
    endcase
  end

  // round-robin offset memory
  always_ff @(posedge clk) begin
    if (mem_we) rr_mem[mem_wa] <= mem_wd;
    rr_q <= rr_mem[rd_addr];
  end

  // checks
  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    route.valid && route.error |-> route.last_hop && route.hop_number == '0
                                   && route.out_port == '0)
    else $error("error item with hop fields set");

  a_one_route: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("second request taken while a route is in progress");

  a_clear_quiet: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |-> !route.valid && !req.ready)
    else $error("activity during offset initialisation");

  a_div_free: assert property (@(posedge clk) disable iff (rst)
    div_ctl.start |-> !div_sts.busy)
    else $error("divider started while busy");

  a_mca_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_HOP0 |-> m != '0 && m <= ns)
    else $error("common stage out of range");

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
  import udrg_pkg::*;

  localparam int          SERVER_CAP    = 4096;
  localparam int          STAGE_CAP     = 5;
  localparam int          LONG_STALL    = 400;
  localparam int          SETTLE_CYCLES = 150;
  localparam int          DRAIN_LIMIT   = 50000;
  localparam logic [1:0]  MODE_SPARE    = 2'd3;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_kind_t;

  typedef struct packed {
    logic [ID_W-1:0]  src;
    logic [ID_W-1:0]  dst;
    logic [KEY_W-1:0] rnd;
  } route_req_t;

  typedef struct packed {
    logic [PORT_W-1:0] port;
    logic [HOP_W-1:0]  hop;
    logic              last;
    logic              err;
  } route_hop_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  udrg_req_if route_req ();
  udrg_hop_if route_hops ();

  // predictor state: register copy and per-source round-robin keys
  cfg_t            cfg_shadow;
  logic [ID_W-1:0] rr_key [SERVER_CAP];

  route_req_t  pending_reqs [$];
  route_hop_t  hop_q [$];
  int          queued_reqs = 0;
  int          accepted_reqs = 0;
  int          mismatches = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          long_stall_armed = 1'b0;
  int          held_cycles = 0;

  updown_tree_route_generator_core uut (
    .clk     (clk),
    .rst     (rst),
    .req     (route_req),
    .route   (route_hops),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // generous overall limit
  initial begin
    #8_000_000;
    $display("updown_tree_route_generator_core: mismatch");
    $finish;
  end

  function automatic void note_fault(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%s", msg);
  endfunction

  function automatic longint unsigned radix_of(input logic [PACK_W-1:0] packed_r,
                                               input int unsigned s);
    if (s >= STAGE_CAP) return 0;
    return (packed_r >> (8 * s)) & 40'hFF;
  endfunction

  function automatic int unsigned used_stages();
    return (cfg_shadow.stages > STAGE_CAP) ? STAGE_CAP : cfg_shadow.stages;
  endfunction

  // product of the down radices of the stages below l
  function automatic longint unsigned span_below(input int unsigned l);
    longint unsigned p;
    p = 1;
    for (int unsigned s = 0; s < l; s++) p = p * radix_of(cfg_shadow.down_radices, s);
    return p;
  endfunction

  function automatic longint unsigned server_total();
    longint unsigned p;
    p = span_below(used_stages());
    return (p > SERVER_CAP) ? SERVER_CAP : p;
  endfunction

  // expected hops of one accepted request, round-robin key advanced afterwards unless in error
  function automatic void predict_route(input route_req_t rq);
    longint unsigned cnt, key, q, d, u, port, lv;
    int unsigned     ns, m, total;
    route_hop_t      h;
    ns  = used_stages();
    cnt = server_total();
    if (rq.src >= cnt || rq.dst >= cnt) begin
      h.port = '0;
      h.hop  = '0;
      h.last = 1'b1;
      h.err  = 1'b1;
      hop_q.push_back(h);
      return;
    end
    m = 0;
    while (m < ns && rq.src / span_below(m) != rq.dst / span_below(m)) m++;
    case (cfg_shadow.mode)
      MODE_RANDOM: key = rq.rnd;
      MODE_RR:     key = rr_key[rq.src];
      default:     key = rq.src;
    endcase
    total = 2 * m;
    for (int unsigned i = 0; i < total; i++) begin
      if (i == 0) begin
        port = 0;
      end else if (i < m) begin
        d    = radix_of(cfg_shadow.down_radices, i - 1);
        u    = radix_of(cfg_shadow.up_radices, i - 1);
        q    = key / span_below(i - 1);
        port = d + ((u != 0) ? q % u : 0);
      end else begin
        lv   = total - 1 - i;
        d    = radix_of(cfg_shadow.down_radices, lv);
        q    = rq.dst / span_below(lv);
        port = (d != 0) ? q % d : 0;
      end
      h.port = PORT_W'(port);
      h.hop  = HOP_W'(i);
      h.last = (i + 1 == total);
      h.err  = 1'b0;
      hop_q.push_back(h);
    end
    if (cfg_shadow.mode == MODE_RR) rr_key[rq.src] = ID_W'((rr_key[rq.src] + 1) % cnt);
  endfunction

  // request driver
  always @(posedge clk) begin
    route_req_t nxt;
    if (rst) begin
      route_req.valid <= 1'b0;
    end else if (!route_req.valid || route_req.ready) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_reqs.pop_front();
        route_req.valid        <= 1'b1;
        route_req.src_server   <= nxt.src;
        route_req.dst_server   <= nxt.dst;
        route_req.random_value <= nxt.rnd;
      end else begin
        route_req.valid <= 1'b0;
      end
    end
  end

  // hop receiver, with one long hold-off when armed
  always @(posedge clk) begin
    if (rst) begin
      route_hops.ready <= 1'b0;
    end else if (long_stall_armed && held_cycles < LONG_STALL) begin
      route_hops.ready <= 1'b0;
      held_cycles      <= held_cycles + 1;
    end else begin
      route_hops.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // monitor: predict on request, compare on hop
  always @(posedge clk) begin
    route_req_t rq;
    route_hop_t got, want;
    if (!rst) begin
      if (route_req.valid && route_req.ready) begin
        rq.src = route_req.src_server;
        rq.dst = route_req.dst_server;
        rq.rnd = route_req.random_value;
        predict_route(rq);
        accepted_reqs <= accepted_reqs + 1;
      end
      if (route_hops.valid && route_hops.ready) begin
        got.port = route_hops.out_port;
        got.hop  = route_hops.hop_number;
        got.last = route_hops.last_hop;
        got.err  = route_hops.error;
        if (hop_q.size() == 0) begin
          note_fault($sformatf("unexpected hop: port %0d hop %0d last %0b err %0b",
                               got.port, got.hop, got.last, got.err));
        end else begin
          want = hop_q.pop_front();
          if (got.port !== want.port || got.hop !== want.hop ||
              got.last !== want.last || got.err !== want.err)
            note_fault($sformatf({"wrong hop: expected port %0d hop %0d last %0b err %0b,",
                                  " got port %0d hop %0d last %0b err %0b"},
                                 want.port, want.hop, want.last, want.err,
                                 got.port, got.hop, got.last, got.err));
        end
      end
    end
  end

  task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'(int'(idx) << REG_SHIFT);
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:   cfg_shadow.mode         = val[1:0];
      REG_STAGES: cfg_shadow.stages       = val[2:0];
      REG_DOWN:   cfg_shadow.down_radices = val[PACK_W-1:0];
      REG_UP:     cfg_shadow.up_radices   = val[PACK_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [1:0] m, input logic [2:0] st,
                            input logic [PACK_W-1:0] dn, input logic [PACK_W-1:0] up);
    write_reg(REG_MODE, DATA_W'(m));
    write_reg(REG_STAGES, DATA_W'(st));
    write_reg(REG_DOWN, DATA_W'(dn));
    write_reg(REG_UP, DATA_W'(up));
  endtask

  function automatic void set_idle(input idle_kind_t k);
    case (k)
      IDLE_SEND: begin send_idle_pct = 82; recv_stall_pct = 0;  end
      IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 82; end
      IDLE_BOTH: begin send_idle_pct = 17; recv_stall_pct = 17; end
      default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
    endcase
  endfunction

  function automatic void add_item(input int unsigned src, input int unsigned dst,
                                   input logic [KEY_W-1:0] rnd);
    route_req_t rq;
    rq.src = ID_W'(src);
    rq.dst = ID_W'(dst);
    rq.rnd = rnd;
    pending_reqs.push_back(rq);
    queued_reqs++;
  endfunction

  // in-range pairs sharing a random number of upper digits, some noise (most items if cnt <= 1)
  function automatic void add_random(input int n);
    longint unsigned cnt, span;
    int unsigned     src, dst, noise_pct;
    cnt       = server_total();
    noise_pct = (cnt <= 1) ? 60 : 15;
    for (int k = 0; k < n; k++) begin
      if (cnt == 0 || $urandom_range(99) < noise_pct) begin
        src = $urandom_range(SERVER_CAP - 1);
        dst = $urandom_range(SERVER_CAP - 1);
      end else begin
        src  = $urandom_range(int'(cnt) - 1);
        span = span_below($urandom_range(used_stages()));
        if (span > cnt) span = cnt;
        dst = src - src % int'(span) + $urandom_range(int'(span) - 1);
        if (dst >= cnt) dst = $urandom_range(int'(cnt) - 1);
      end
      add_item(src, dst, $urandom());
    end
  endfunction

  // wait for every request to be taken and every hop to arrive, then let the block go quiet
  task automatic drain_and_settle();
    int guard;
    while (accepted_reqs != queued_reqs) @(posedge clk);
    guard = 0;
    while (hop_q.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    if (hop_q.size() != 0) begin
      note_fault($sformatf("%0d expected hops never arrived", hop_q.size()));
      hop_q.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_phase(input logic [1:0] m, input logic [2:0] st,
                              input logic [PACK_W-1:0] dn, input logic [PACK_W-1:0] up,
                              input int n, input idle_kind_t k, input bit hold);
    set_config(m, st, dn, up);
    set_idle(k);
    if (hold) long_stall_armed = 1'b1;
    add_random(n);
    drain_and_settle();
  endtask

  initial begin
    rst                    = 1'b1;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    route_req.valid        = 1'b0;
    route_req.src_server   = '0;
    route_req.dst_server   = '0;
    route_req.random_value = '0;
    route_hops.ready       = 1'b0;
    cfg_shadow.mode         = MODE_STATIC;
    cfg_shadow.stages       = 3'd1;
    cfg_shadow.down_radices = 40'd2;
    cfg_shadow.up_radices   = 40'd1;
    for (int i = 0; i < SERVER_CAP; i++) rr_key[i] = ID_W'(i);
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset settings: two servers
    add_item(0, 1, 0);
    add_item(1, 0, 0);
    add_item(1, 1, 0);
    add_item(2, 1, 0);
    add_item(0, 4095, 0);
    drain_and_settle();

    // four stages of radix four, zero up radix at the top
    set_config(MODE_STATIC, 3'd4, 40'h04040404, 40'h0000010302);
    add_item(0, 255, 0);
    add_item(255, 0, 0);
    add_item(5, 6, 0);
    add_item(17, 17, 0);
    add_item(256, 0, 0);
    add_item(0, 4095, 0);
    drain_and_settle();
    write_reg(REG_MODE, DATA_W'(MODE_RANDOM));
    add_item(3, 200, 32'h0000_0000);
    add_item(3, 200, 32'hFFFF_FFFF);
    add_item(200, 3, 32'hA5A5_5A5A);
    drain_and_settle();
    write_reg(REG_MODE, DATA_W'(MODE_RR));
    add_item(7, 250, 0);
    add_item(7, 250, 0);
    add_item(7, 250, 0);
    add_item(7, 7, 0);
    add_item(7, 100, 0);
    drain_and_settle();
    write_reg(REG_MODE, DATA_W'(MODE_SPARE));
    add_item(9, 99, 32'h1234_5678);
    add_item(99, 9, 32'h8765_4321);
    drain_and_settle();

    // random phases over a range of tree shapes
    random_phase(MODE_STATIC, 3'd3, 40'h02_08_04, 40'h05_02_03, 35, IDLE_NONE, 1'b0);
    random_phase(MODE_RANDOM, 3'd5, 40'h08_08_08_08_08, 40'h01_10_03_07_FF, 35, IDLE_SEND,
                 1'b0);
    random_phase(MODE_RR, 3'd4, 40'h04_04_04_04, 40'h04_04_04_04, 35, IDLE_RECV, 1'b0);
    random_phase(MODE_SPARE, 3'd2, 40'h10_FF, 40'hFF_00, 35, IDLE_BOTH, 1'b0);
    random_phase(MODE_RR, 3'd5, 40'h02_02_02_02_02, 40'h02_02_02_02_02, 35, IDLE_NONE, 1'b1);
    random_phase(MODE_RANDOM, 3'd7, 40'h03_02_07_05_03, 40'h00_09_01_80_FF, 35, IDLE_SEND,
                 1'b0);
    random_phase(MODE_STATIC, 3'd0, 40'h0, 40'h0, 15, IDLE_RECV, 1'b0);
    random_phase(MODE_RR, 3'd1, 40'hFF, 40'hFF, 35, IDLE_BOTH, 1'b0);
    random_phase(MODE_STATIC, 3'd5, 40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 35, IDLE_NONE, 1'b0);
    random_phase(MODE_STATIC, 3'd3, 40'h04_00_04, 40'h03_02_01, 15, IDLE_SEND, 1'b0);
    random_phase(MODE_RANDOM, 3'd6, 40'h01_01_10_10_10, 40'h09_07_05_03_02, 35, IDLE_RECV,
                 1'b0);
    random_phase(MODE_RR, 3'd3, 40'h10_10_10, 40'h03_02_01, 35, IDLE_BOTH, 1'b0);

    if (mismatches == 0) begin
      $display("updown_tree_route_generator_core: match");
    end else begin
      $display("updown_tree_route_generator_core: mismatch");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/udrg_pkg.sv
rtl/udrg_ifs.sv
rtl/udrg_regs.sv
rtl/udrg_div.sv
rtl/updown_tree_route_generator_core.sv
test/tb_top.sv
